// ===== rtl/assert_macros.svh =====
// assertion macros used by the rtl core file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// condition holds at every clock edge outside reset
`define SUKL_ASSERT_ALWAYS(label, cond) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (cond)) \
		else $error("sorted key list: invariant violated");

// consequent holds in the same cycle as the antecedent
`define SUKL_ASSERT_IMPL(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("sorted key list: implication violated");

// consequent holds in the cycle after the antecedent
`define SUKL_ASSERT_NEXT(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("sorted key list: next-cycle implication violated");

`endif

// ===== rtl/sukl_pkg.sv =====
// types and constants of the sorted unique key list
package sukl_pkg;

	// default list depth
	localparam int unsigned CAPACITY_DEF = 16;

	// configuration register width and reset value
	localparam int unsigned CFG_W = 5;
	localparam logic [CFG_W-1:0] CAP_RESET = 5'd16;

	// width of the position field
	localparam int unsigned POS_W = 4;

	// action codes
	localparam logic [1:0] ACT_INSERT = 2'd0;
	localparam logic [1:0] ACT_SEARCH = 2'd1;
	localparam logic [1:0] ACT_REMOVE = 2'd2;
	localparam logic [1:0] ACT_SHOW   = 2'd3;

	// result kinds
	localparam logic KIND_SEARCH = 1'b0;
	localparam logic KIND_LIST   = 1'b1;

	// request payload
	typedef struct packed {
		logic [1:0]         action;
		logic signed [31:0] key;
	} req_t;

	// result payload
	typedef struct packed {
		logic               result_kind;
		logic               found;
		logic [POS_W-1:0]   position;
		logic signed [31:0] element_value;
		logic               last_element;
	} rsp_t;

endpackage

// ===== rtl/sorted_unique_key_list_core.sv =====
// sorted unique key list: key memory, scan/shift sequencer and result register
//
//  channel | direction | handshake                  | payload
//  --------+-----------+----------------------------+---------------------
//  req     | in        | req_valid / req_ready      | req_data (action, key)
//  rsp     | out       | rsp_valid / rsp_ready      | rsp_data (result fields)
//  cfg     | in        | cfg_wr_en                  | cfg_wr_data (capacity)
//
// one request at a time through a single memory read port and one signed compare
// scan: reads then compares each key examined, stops at the first key not below the operand
// insert shift: reads then writes each moved key, then places the key; remove: reads then writes each moved key
// show: reads then outputs each key, holding while a result is pending and rsp_ready stays low
// reset clears the key count and sets capacity to 16; key memory is not cleared
`include "assert_macros.svh"

module sorted_unique_key_list_core #(
	parameter int unsigned CAPACITY = sukl_pkg::CAPACITY_DEF
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        req_valid,
	output logic                        req_ready,
	input  sukl_pkg::req_t              req_data,
	output logic                        rsp_valid,
	input  logic                        rsp_ready,
	output sukl_pkg::rsp_t              rsp_data,
	input  logic                        cfg_wr_en,
	input  logic [sukl_pkg::CFG_W-1:0]  cfg_wr_data
);

	// count width holds CAPACITY itself, address width indexes the memory
	localparam int unsigned CW = $clog2(CAPACITY + 1);
	localparam int unsigned AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
	localparam int unsigned LW = (CW > sukl_pkg::CFG_W) ? CW : sukl_pkg::CFG_W;
	localparam logic [LW-1:0] CAP_L = LW'(CAPACITY);

	// sequencer states
	localparam logic [3:0] ST_IDLE     = 4'd0;
	localparam logic [3:0] ST_SCAN_RD  = 4'd1;
	localparam logic [3:0] ST_SCAN_CMP = 4'd2;
	localparam logic [3:0] ST_FINISH   = 4'd3;
	localparam logic [3:0] ST_INS_RD   = 4'd4;
	localparam logic [3:0] ST_INS_WR   = 4'd5;
	localparam logic [3:0] ST_INS_PUT  = 4'd6;
	localparam logic [3:0] ST_REM_RD   = 4'd7;
	localparam logic [3:0] ST_REM_WR   = 4'd8;
	localparam logic [3:0] ST_SHOW_RD  = 4'd9;
	localparam logic [3:0] ST_SHOW_OUT = 4'd10;

	logic [3:0]                  state_q, state_d;
	logic [sukl_pkg::CFG_W-1:0]  cap_q;
	logic [CW-1:0]               count_q, count_d;
	logic [CW-1:0]               idx_q, idx_d;
	logic [CW-1:0]               at_q, at_d;
	logic                        hit_q, hit_d;
	logic [1:0]                  action_q;
	logic signed [31:0]          key_q;
	logic signed [31:0]          rdata_q;
	logic [31:0]                 mem [CAPACITY];

	logic                        mem_we;
	logic [AW-1:0]               mem_waddr;
	logic [31:0]                 mem_wdata;

	logic                        rsp_valid_q;
	sukl_pkg::rsp_t              rsp_q, rsp_d;
	logic                        rsp_load;
	logic                        rsp_free;

	logic                        req_accept;
	logic                        list_full;
	logic [CW-1:0]               idx_inc, idx_dec, count_dec;
	logic [LW-1:0]               idx_l;
	logic [LW-1:0]               at_l;
	logic                        key_eq, key_lt;

	assign req_ready  = (state_q == ST_IDLE);
	assign req_accept = req_valid && req_ready;
	assign rsp_valid  = rsp_valid_q;
	assign rsp_data   = rsp_q;
	assign rsp_free   = !rsp_valid_q || rsp_ready;

	assign idx_inc   = idx_q + 1'b1;
	assign idx_dec   = idx_q - 1'b1;
	assign count_dec = count_q - 1'b1;
	assign idx_l     = LW'(idx_q);
	assign at_l      = LW'(at_q);

	// shared compare unit
	assign key_eq = (rdata_q == key_q);
	assign key_lt = (rdata_q < key_q);

	// full when at the configured limit or at the memory depth
	assign list_full = (LW'(count_q) >= LW'(cap_q)) || (LW'(count_q) == CAP_L);

	// capacity register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cap_q <= sukl_pkg::CAP_RESET;
		end else if (cfg_wr_en) begin
			cap_q <= cfg_wr_data;
		end
	end

	// key memory, one write and one registered read per cycle
	always_ff @(posedge clk) begin
		if (mem_we) begin
			mem[mem_waddr] <= mem_wdata;
		end
		rdata_q <= mem[idx_q[AW-1:0]];
	end

	// request operand capture
	always_ff @(posedge clk) begin
		if (req_accept) begin
			action_q <= req_data.action;
			key_q    <= req_data.key;
		end
	end

	// sequencer next state, memory writes and result load
	always_comb begin
		state_d   = state_q;
		count_d   = count_q;
		idx_d     = idx_q;
		at_d      = at_q;
		hit_d     = hit_q;
		mem_we    = 1'b0;
		mem_waddr = idx_q[AW-1:0];
		mem_wdata = rdata_q;
		rsp_load  = 1'b0;
		rsp_d     = rsp_q;
		unique case (state_q)
			ST_IDLE: begin
				if (req_accept) begin
					idx_d = '0;
					hit_d = 1'b0;
					case (req_data.action)
						sukl_pkg::ACT_INSERT: state_d = list_full ? ST_IDLE : ST_SCAN_RD;
						sukl_pkg::ACT_SHOW:   state_d = (count_q == '0) ? ST_IDLE : ST_SHOW_RD;
						default:              state_d = ST_SCAN_RD;
					endcase
				end
			end
			ST_SCAN_RD: begin
				if (idx_q == count_q) begin
					at_d    = idx_q;
					hit_d   = 1'b0;
					state_d = ST_FINISH;
				end else begin
					state_d = ST_SCAN_CMP;
				end
			end
			ST_SCAN_CMP: begin
				if (!key_lt) begin
					at_d    = idx_q;
					hit_d   = key_eq;
					state_d = ST_FINISH;
				end else begin
					idx_d   = idx_inc;
					state_d = ST_SCAN_RD;
				end
			end
			ST_FINISH: begin
				case (action_q)
					sukl_pkg::ACT_SEARCH: begin
						if (rsp_free) begin
							rsp_load            = 1'b1;
							rsp_d.result_kind   = sukl_pkg::KIND_SEARCH;
							rsp_d.found         = hit_q;
							rsp_d.position      = hit_q ? at_l[sukl_pkg::POS_W-1:0] : '0;
							rsp_d.element_value = '0;
							rsp_d.last_element  = 1'b1;
							state_d             = ST_IDLE;
						end
					end
					sukl_pkg::ACT_INSERT: begin
						if (hit_q) begin
							state_d = ST_IDLE;
						end else if (at_q == count_q) begin
							state_d = ST_INS_PUT;
						end else begin
							idx_d   = count_dec;
							state_d = ST_INS_RD;
						end
					end
					default: begin
						// remove: close the gap above the matching key
						if (!hit_q) begin
							state_d = ST_IDLE;
						end else if (CW'(at_q + 1'b1) == count_q) begin
							count_d = count_dec;
							state_d = ST_IDLE;
						end else begin
							idx_d   = CW'(at_q + 1'b1);
							state_d = ST_REM_RD;
						end
					end
				endcase
			end
			ST_INS_RD: begin
				state_d = ST_INS_WR;
			end
			ST_INS_WR: begin
				mem_we    = 1'b1;
				mem_waddr = idx_inc[AW-1:0];
				if (idx_q == at_q) begin
					state_d = ST_INS_PUT;
				end else begin
					idx_d   = idx_dec;
					state_d = ST_INS_RD;
				end
			end
			ST_INS_PUT: begin
				mem_we    = 1'b1;
				mem_waddr = at_q[AW-1:0];
				mem_wdata = key_q;
				count_d   = count_q + 1'b1;
				state_d   = ST_IDLE;
			end
			ST_REM_RD: begin
				state_d = ST_REM_WR;
			end
			ST_REM_WR: begin
				mem_we    = 1'b1;
				mem_waddr = idx_dec[AW-1:0];
				if (idx_inc == count_q) begin
					count_d = count_dec;
					state_d = ST_IDLE;
				end else begin
					idx_d   = idx_inc;
					state_d = ST_REM_RD;
				end
			end
			ST_SHOW_RD: begin
				state_d = ST_SHOW_OUT;
			end
			ST_SHOW_OUT: begin
				if (rsp_free) begin
					rsp_load            = 1'b1;
					rsp_d.result_kind   = sukl_pkg::KIND_LIST;
					rsp_d.found         = 1'b0;
					rsp_d.position      = idx_l[sukl_pkg::POS_W-1:0];
					rsp_d.element_value = rdata_q;
					rsp_d.last_element  = (idx_inc == count_q);
					if (idx_inc == count_q) begin
						state_d = ST_IDLE;
					end else begin
						idx_d   = idx_inc;
						state_d = ST_SHOW_RD;
					end
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	// sequencer registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			count_q <= '0;
			idx_q   <= '0;
			at_q    <= '0;
			hit_q   <= 1'b0;
		end else begin
			state_q <= state_d;
			count_q <= count_d;
			idx_q   <= idx_d;
			at_q    <= at_d;
			hit_q   <= hit_d;
		end
	end

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid_q <= 1'b0;
		end else if (rsp_load) begin
			rsp_valid_q <= 1'b1;
		end else if (rsp_ready) begin
			rsp_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (rsp_load) begin
			rsp_q <= rsp_d;
		end
	end

	// assertions
	`SUKL_ASSERT_ALWAYS(a_count_in_range, LW'(count_q) <= CAP_L)
	`SUKL_ASSERT_NEXT(a_insert_grows, state_q == ST_INS_PUT, count_q == CW'($past(count_q) + 1'b1))
	`SUKL_ASSERT_IMPL(a_rsp_source, $rose(rsp_valid_q), $past(state_q) == ST_FINISH || $past(state_q) == ST_SHOW_OUT)
	`SUKL_ASSERT_IMPL(a_no_load_on_stall, rsp_load, !rsp_valid_q || rsp_ready)

endmodule
